/* src/mbb_pkg.sv */
// Shared types, constants and helpers for the MSB-first bit buffer.
// Used by mbb_ctrl, mbb_datapath and msb_first_bit_buffer_top.
package mbb_pkg;

  // Store size in bytes; capacity is eight bits per byte.
  localparam int BUFFER_BYTES = 64;
  localparam int CAP_BITS     = BUFFER_BYTES * 8;

  // Bit positions run 0..CAP_BITS inclusive.
  localparam int POS_W  = $clog2(CAP_BITS + 1);
  localparam int BYTE_W = POS_W - 3;

  // Store is split into even and odd byte banks so two adjacent bytes
  // can be read or written together.
  localparam int BANK_DEPTH = (BUFFER_BYTES + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // Stream payload widths, packed to whole bytes.
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [BYTE_W-1:0]  byte_idx_t;
  typedef logic [BANK_AW-1:0] bank_idx_t;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_PULL    = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_RESTART = 2'd3
  } action_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture the input request
    logic rd;    // read both banks at the access position
    logic exec;  // update store and positions, load the result
  } mbb_cmd_t;

  // Top n bits set, n in 0..8.
  function automatic logic [7:0] top_mask(input logic [3:0] n);
    return ~(8'hFF >> n);
  endfunction

endpackage

/* src/mbb_ctrl.sv */
// Sequencer for the bit buffer: handshakes and read/execute stepping.
// Depends on mbb_pkg for the command struct.
module mbb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output mbb_pkg::mbb_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   m_tvalid_q;
  logic   out_free;
  logic   load;

  assign s_tready_o = (state_q != ST_READ);
  assign load       = s_tvalid_i & s_tready_o;
  // Result slot can take a new result this cycle.
  assign out_free   = ~m_tvalid_q | m_tready_i;

  assign cmd_o.load = load;
  assign cmd_o.rd   = (state_q == ST_READ);
  assign cmd_o.exec = (state_q == ST_EXEC);

  assign m_tvalid_o = m_tvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_tvalid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (load) state_q <= ST_READ;
        end
        ST_READ: begin
          // hold the read until the previous result has left
          if (out_free) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          state_q <= load ? ST_READ : ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase

      if (state_q == ST_EXEC) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !m_tvalid_q)
    else $error("result written over a pending result");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> m_tvalid_o)
    else $error("execute step did not present a result");

  a_read_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && !out_free) |=> (state_q == ST_READ))
    else $error("read step left while output slot busy");
`endif

endmodule

/* src/mbb_datapath.sv */
// Datapath of the bit buffer: request registers, positions, banked byte
// store with valid bits, window extract/merge and result registers. Uses mbb_pkg.
module mbb_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbb_pkg::mbb_cmd_t cmd_i,
  input  logic [1:0]        action_i,
  input  logic [7:0]        data_in_i,
  input  logic [3:0]        req_bits_i,
  input  logic [9:0]        start_bits_i,
  output logic [7:0]        data_out_o,
  output logic [3:0]        moved_bits_o,
  output logic [9:0]        available_bits_o
);

  // Request registers
  mbb_pkg::action_e action_q;
  logic [7:0]       data_q;
  logic [3:0]       count_q;
  mbb_pkg::pos_t    start_q;

  // Positions
  mbb_pkg::pos_t wr_pos_q, wr_pos_d;
  mbb_pkg::pos_t rd_pos_q, rd_pos_d;

  // Banked store
  logic [7:0] even_mem [mbb_pkg::BANK_DEPTH];
  logic [7:0] odd_mem  [mbb_pkg::BANK_DEPTH];
  logic [mbb_pkg::BANK_DEPTH-1:0] even_vld_q;
  logic [mbb_pkg::BANK_DEPTH-1:0] odd_vld_q;

  // Read stage
  mbb_pkg::pos_t         acc_pos;
  mbb_pkg::byte_idx_t    acc_byte;
  logic [mbb_pkg::BYTE_W:0] acc_byte1;
  mbb_pkg::bank_idx_t    even_idx, odd_idx;
  mbb_pkg::bank_idx_t    even_idx_q, odd_idx_q;
  logic [7:0]            rd_even_q, rd_odd_q;
  logic                  b_odd_q, hi_ok_q, lo_ok_q;
  logic [2:0]            off_q;

  // Execute stage
  logic [7:0]    hi_byte, lo_byte;
  logic [15:0]   window;
  logic [15:0]   wshift;
  logic [7:0]    new_hi, new_lo;
  mbb_pkg::pos_t room, avail;
  logic [3:0]    push_moved, pull_moved;
  logic [3:0]    moved;
  logic [7:0]    dout;
  logic          wr_hi, wr_lo;
  logic          even_we, odd_we;
  logic [7:0]    even_wd, odd_wd;

  mbb_pkg::pos_t start_clamped;
  assign start_clamped = (32'(start_bits_i) > mbb_pkg::CAP_BITS)
                         ? mbb_pkg::pos_t'(mbb_pkg::CAP_BITS)
                         : mbb_pkg::pos_t'(start_bits_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= mbb_pkg::action_e'(action_i);
      data_q   <= data_in_i;
      count_q  <= (req_bits_i > 4'd8) ? 4'd8 : req_bits_i;
      start_q  <= start_clamped;
    end
  end

  // Byte p/8 and the one after it; even bank holds byte 2k at k, odd holds 2k+1.
  assign acc_pos   = (action_q == mbb_pkg::ACT_PUSH) ? wr_pos_q : rd_pos_q;
  assign acc_byte  = acc_pos[mbb_pkg::POS_W-1:3];
  assign acc_byte1 = {1'b0, acc_byte} + 1'b1;
  assign even_idx  = mbb_pkg::bank_idx_t'(acc_byte1 >> 1);
  assign odd_idx   = mbb_pkg::bank_idx_t'(acc_byte >> 1);

  // Store banks: one write and one read port each
  always_ff @(posedge clk_i) begin
    if (even_we) even_mem[even_idx_q] <= even_wd;
    if (odd_we)  odd_mem[odd_idx_q]   <= odd_wd;
    if (cmd_i.rd) begin
      rd_even_q  <= even_vld_q[even_idx] ? even_mem[even_idx] : 8'h00;
      rd_odd_q   <= odd_vld_q[odd_idx] ? odd_mem[odd_idx] : 8'h00;
      even_idx_q <= even_idx;
      odd_idx_q  <= odd_idx;
      b_odd_q    <= acc_byte[0];
      off_q      <= acc_pos[2:0];
      hi_ok_q    <= 32'(acc_byte) < mbb_pkg::BUFFER_BYTES;
      lo_ok_q    <= 32'(acc_byte1) < mbb_pkg::BUFFER_BYTES;
    end
  end

  // Unwritten entries read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      even_vld_q <= '0;
      odd_vld_q  <= '0;
    end else begin
      if (even_we) even_vld_q[even_idx_q] <= 1'b1;
      if (odd_we)  odd_vld_q[odd_idx_q]   <= 1'b1;
    end
  end

  assign hi_byte = hi_ok_q ? (b_odd_q ? rd_odd_q : rd_even_q) : 8'h00;
  assign lo_byte = lo_ok_q ? (b_odd_q ? rd_even_q : rd_odd_q) : 8'h00;
  assign window  = {hi_byte, lo_byte} << off_q;
  assign wshift  = {data_q, 8'h00} >> off_q;
  assign new_hi  = (hi_byte & ~(8'hFF >> off_q)) | wshift[15:8];
  assign new_lo  = wshift[7:0];

  assign room  = mbb_pkg::pos_t'(mbb_pkg::CAP_BITS) - wr_pos_q;
  assign avail = wr_pos_q - rd_pos_q;
  // when clamped, the limit is at most 8 and fits in four bits
  assign push_moved = (mbb_pkg::pos_t'(count_q) < room)  ? count_q : room[3:0];
  assign pull_moved = (mbb_pkg::pos_t'(count_q) < avail) ? count_q : avail[3:0];

  always_comb begin
    moved    = 4'd0;
    dout     = 8'h00;
    wr_hi    = 1'b0;
    wr_lo    = 1'b0;
    wr_pos_d = wr_pos_q;
    rd_pos_d = rd_pos_q;
    case (action_q)
      mbb_pkg::ACT_PUSH: begin
        moved    = push_moved;
        wr_hi    = (push_moved != 4'd0) && hi_ok_q;
        wr_lo    = wr_hi && lo_ok_q;
        wr_pos_d = wr_pos_q + mbb_pkg::pos_t'(push_moved);
      end
      mbb_pkg::ACT_PULL: begin
        moved    = pull_moved;
        dout     = window[15:8] & mbb_pkg::top_mask(pull_moved);
        rd_pos_d = rd_pos_q + mbb_pkg::pos_t'(pull_moved);
      end
      mbb_pkg::ACT_PEEK: begin
        moved = pull_moved;
        dout  = window[15:8] & mbb_pkg::top_mask(pull_moved);
      end
      mbb_pkg::ACT_RESTART: begin
        wr_pos_d = start_q;
        rd_pos_d = '0;
      end
      default: ;
    endcase
  end

  // Head byte and next byte always sit in opposite banks
  assign even_we = cmd_i.exec & (b_odd_q ? wr_lo : wr_hi);
  assign odd_we  = cmd_i.exec & (b_odd_q ? wr_hi : wr_lo);
  assign even_wd = b_odd_q ? new_lo : new_hi;
  assign odd_wd  = b_odd_q ? new_hi : new_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos_q <= '0;
      rd_pos_q <= '0;
    end else if (cmd_i.exec) begin
      wr_pos_q <= wr_pos_d;
      rd_pos_q <= rd_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      data_out_o       <= dout;
      moved_bits_o     <= moved;
      available_bits_o <= 10'(wr_pos_d - rd_pos_d);
    end
  end

`ifndef SYNTHESIS
  a_rd_le_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pos_q <= wr_pos_q)
    else $error("read position passed write position");

  a_wr_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pos_q <= mbb_pkg::pos_t'(mbb_pkg::CAP_BITS))
    else $error("write position beyond capacity");

  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> ($stable(wr_pos_q) && $stable(rd_pos_q)))
    else $error("positions moved outside execute step");
`endif

endmodule

/* src/msb_first_bit_buffer_top.sv */
// MSB-first bit buffer: requests in on s_*, one result per request on m_*.
// Usage
//   Request (s_tdata): action 0 push, 1 pull, 2 peek, 3 restart; data_in,
//   req_bits (above 8 acts as 8) and start_bits. Push appends bits at the
//   write position, pull/peek return bits MSB-aligned from the read position,
//   restart sets the write position to start_bits (saturated at capacity) and
//   the read position to 0 while keeping the stored bytes.
//   Result (m_tdata): data_out, moved_bits after clamping, available_bits.
// Timing
//   An accepted request goes through a read step, which reads the two
//   adjacent store bytes from the even/odd banks and waits while a held
//   result blocks the output, then an execute step, which merges, writes
//   back and loads the result register, raising m_tvalid. A new request
//   can be taken during the execute step of the previous one.
// Stall: when m_tready is low the next request may still be taken, but its
//   read step waits until the held result is taken; s_tready stays low then.
// Reset: positions go to zero and per-entry valid bits make the whole store
//   read as zero at once; no clearing pass is needed.
// Depends on mbb_pkg, mbb_ctrl and mbb_datapath.
module msb_first_bit_buffer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] action, [9:2] data_in, [13:10] req_bits, [23:14] start_bits
  input  logic [mbb_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] data_out, [11:8] moved_bits, [21:12] available_bits, [23:22] zero
  output logic [mbb_pkg::OUT_TDATA_W-1:0] m_tdata
);

  mbb_pkg::mbb_cmd_t cmd;
  logic [7:0]        data_out;
  logic [3:0]        moved_bits;
  logic [9:0]        available_bits;

  mbb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .cmd_o      (cmd)
  );

  mbb_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .action_i         (s_tdata[1:0]),
    .data_in_i        (s_tdata[9:2]),
    .req_bits_i       (s_tdata[13:10]),
    .start_bits_i     (s_tdata[23:14]),
    .data_out_o       (data_out),
    .moved_bits_o     (moved_bits),
    .available_bits_o (available_bits)
  );

  assign m_tdata = {2'b00, available_bits, moved_bits, data_out};

endmodule
